// File: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared types, defaults and width helpers for the matrix-to-quaternion pipe.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 14;

    typedef enum logic [1:0] {
        SEL_W,
        SEL_X,
        SEL_Y,
        SEL_Z
    } t_sel;

    typedef struct packed {
        t_sel       sel;
        logic [2:0] neg;
    } t_ctl;

    // width of (t + one), t being a diagonal sum
    function automatic int sum_w(input int dw, input int f);
        int tw;
        tw = dw + 2;
        return (((tw - 1) > (f + 1)) ? (tw - 1) : (f + 1)) + 1;
    endfunction

    // radicand width, rounded up to even
    function automatic int rad_w(input int dw, input int f);
        int rw;
        rw = sum_w(dw, f) + f - 2;
        return rw + (rw % 2);
    endfunction

    function automatic int root_w(input int dw, input int f);
        return rad_w(dw, f) / 2;
    endfunction

    // width of a scaled difference magnitude (dividend)
    function automatic int num_w(input int dw, input int f);
        return dw + f - 1;
    endfunction

endpackage

// File: rtl/rmq_front.sv
// ----------------------------------------------------------------------------
// rmq_front
// Diagonal sums, largest-term pick, radicand and difference magnitudes.
// ----------------------------------------------------------------------------
module rmq_front #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic signed [DATA_WIDTH-1:0] i_m [9],
    output logic                         o_valid,
    output logic [rmq_pkg::rad_w(DATA_WIDTH, FRAC_BITS)-1:0] o_rad,
    output rmq_pkg::t_ctl                o_ctl,
    output logic [DATA_WIDTH:0]          o_mag [3]
);

    localparam int TW  = DATA_WIDTH + 2;
    localparam int DMW = DATA_WIDTH + 1;
    localparam int AW  = rmq_pkg::sum_w(DATA_WIDTH, FRAC_BITS);
    localparam int RW  = rmq_pkg::rad_w(DATA_WIDTH, FRAC_BITS);

    logic signed [TW-1:0]  n_t [4];
    logic signed [DMW-1:0] n_d [3];
    logic signed [TW-1:0]  r_t [4];
    logic signed [DMW-1:0] r_d [3];
    logic                  r_v1;

    logic                  r_v2;
    logic [RW-1:0]         r_rad;
    rmq_pkg::t_ctl         r_ctl;
    logic [DMW-1:0]        r_mag [3];

    rmq_pkg::t_sel         w_sel;
    logic signed [TW-1:0]  w_bt;
    logic [AW-1:0]         w_sum;
    logic [RW-1:0]         n_rad;
    logic [2:0]            n_neg;
    logic [DMW-1:0]        n_mag [3];

    always_comb begin
        n_t[0] = TW'(i_m[0]) + TW'(i_m[4]) + TW'(i_m[8]);
        n_t[1] = TW'(i_m[0]) - TW'(i_m[4]) - TW'(i_m[8]);
        n_t[2] = TW'(i_m[4]) - TW'(i_m[0]) - TW'(i_m[8]);
        n_t[3] = TW'(i_m[8]) - TW'(i_m[0]) - TW'(i_m[4]);
        n_d[0] = DMW'(i_m[7]) - DMW'(i_m[5]);
        n_d[1] = DMW'(i_m[2]) - DMW'(i_m[6]);
        n_d[2] = DMW'(i_m[3]) - DMW'(i_m[1]);
    end

    always_comb begin
        w_sel = rmq_pkg::SEL_W;
        w_bt  = r_t[0];
        if (r_t[1] > w_bt) begin
            w_sel = rmq_pkg::SEL_X;
            w_bt  = r_t[1];
        end
        if (r_t[2] > w_bt) begin
            w_sel = rmq_pkg::SEL_Y;
            w_bt  = r_t[2];
        end
        if (r_t[3] > w_bt) begin
            w_sel = rmq_pkg::SEL_Z;
            w_bt  = r_t[3];
        end
        // largest sum is never negative
        w_sum = AW'(unsigned'(w_bt)) + (AW'(1) << FRAC_BITS);
        n_rad = RW'(w_sum) << (FRAC_BITS - 2);
        for (int k = 0; k < 3; k++) begin
            n_neg[k] = r_d[k][DMW-1];
            n_mag[k] = n_neg[k] ? DMW'(-r_d[k]) : DMW'(r_d[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t       <= n_t;
            r_d       <= n_d;
            r_rad     <= n_rad;
            r_ctl.sel <= w_sel;
            r_ctl.neg <= n_neg;
            r_mag     <= n_mag;
        end
    end

    assign o_valid = r_v2;
    assign o_rad   = r_rad;
    assign o_ctl   = r_ctl;
    assign o_mag   = r_mag;

endmodule

// File: rtl/rmq_sqrt.sv
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [rmq_pkg::rad_w(DATA_WIDTH, FRAC_BITS)-1:0] i_rad,
    input  rmq_pkg::t_ctl       i_ctl,
    input  logic [DATA_WIDTH:0] i_mag [3],
    output logic                o_valid,
    output logic [rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS)-1:0] o_root,
    output rmq_pkg::t_ctl       o_ctl,
    output logic [DATA_WIDTH:0] o_mag [3]
);

    localparam int RW  = rmq_pkg::rad_w(DATA_WIDTH, FRAC_BITS);
    localparam int RQ  = rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS);
    localparam int DMW = DATA_WIDTH + 1;

    logic                r_v    [RQ];
    logic [RW-1:0]       r_rad  [RQ];
    logic [RQ+1:0]       r_rem  [RQ];
    logic [RQ-1:0]       r_root [RQ];
    rmq_pkg::t_ctl       r_ctl  [RQ];
    logic [DMW-1:0]      r_mag  [RQ][3];

    genvar j;
    generate
        for (j = 0; j < RQ; j++) begin : g_stage
            logic           p_v;
            logic [RW-1:0]  p_rad;
            logic [RQ+1:0]  p_rem;
            logic [RQ-1:0]  p_root;
            rmq_pkg::t_ctl  p_ctl;
            logic [DMW-1:0] p_mag [3];
            logic [RQ+1:0]  w_sh;
            logic [RQ+1:0]  w_try;
            logic           w_ge;

            if (j == 0) begin : g_first
                assign p_v    = i_valid;
                assign p_rad  = i_rad;
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_ctl  = i_ctl;
                assign p_mag  = i_mag;
            end else begin : g_next
                assign p_v    = r_v[j-1];
                assign p_rad  = r_rad[j-1];
                assign p_rem  = r_rem[j-1];
                assign p_root = r_root[j-1];
                assign p_ctl  = r_ctl[j-1];
                assign p_mag  = r_mag[j-1];
            end

            assign w_sh  = {p_rem[RQ-1:0], p_rad[RW-1-2*j -: 2]};
            assign w_try = {p_root, 2'b01};
            assign w_ge  = (w_sh >= w_try);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[j] <= 1'b0;
                end else if (i_en) begin
                    r_v[j] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rad[j]  <= p_rad;
                    r_rem[j]  <= w_ge ? (w_sh - w_try) : w_sh;
                    r_root[j] <= {p_root[RQ-2:0], w_ge};
                    r_ctl[j]  <= p_ctl;
                    r_mag[j]  <= p_mag;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[RQ-1];
    assign o_root  = r_root[RQ-1];
    assign o_ctl   = r_ctl[RQ-1];
    assign o_mag   = r_mag[RQ-1];

endmodule

// File: rtl/rmq_div.sv
// ----------------------------------------------------------------------------
// rmq_div
// Three-lane pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module rmq_div #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  logic [rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS)-1:0] i_big,
    input  rmq_pkg::t_ctl       i_ctl,
    input  logic [DATA_WIDTH:0] i_mag [3],
    output logic                o_valid,
    output logic [rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS)-1:0] o_big,
    output rmq_pkg::t_ctl       o_ctl,
    output logic [rmq_pkg::num_w(DATA_WIDTH, FRAC_BITS)-1:0] o_quo [3]
);

    localparam int RQ = rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS);
    localparam int NW = rmq_pkg::num_w(DATA_WIDTH, FRAC_BITS);

    logic           r_v   [NW];
    logic [RQ-1:0]  r_big [NW];
    rmq_pkg::t_ctl  r_ctl [NW];
    logic [NW-1:0]  r_num [NW][3];
    logic [RQ-1:0]  r_rem [NW][3];
    logic [NW-1:0]  r_quo [NW][3];

    genvar i, k;
    generate
        for (i = 0; i < NW; i++) begin : g_stage
            logic          p_v;
            logic [RQ-1:0] p_big;
            rmq_pkg::t_ctl p_ctl;
            logic [NW-1:0] p_num [3];
            logic [RQ-1:0] p_rem [3];
            logic [NW-1:0] p_quo [3];

            if (i == 0) begin : g_first
                assign p_v   = i_valid;
                assign p_big = i_big;
                assign p_ctl = i_ctl;
                for (k = 0; k < 3; k++) begin : g_in
                    assign p_num[k] = NW'(i_mag[k]) << (FRAC_BITS - 2);
                    assign p_rem[k] = '0;
                    assign p_quo[k] = '0;
                end
            end else begin : g_next
                assign p_v   = r_v[i-1];
                assign p_big = r_big[i-1];
                assign p_ctl = r_ctl[i-1];
                assign p_num = r_num[i-1];
                assign p_rem = r_rem[i-1];
                assign p_quo = r_quo[i-1];
            end

            for (k = 0; k < 3; k++) begin : g_lane
                logic [RQ:0] w_sh;
                logic        w_ge;
                assign w_sh = {p_rem[k], p_num[k][NW-1-i]};
                assign w_ge = (w_sh >= {1'b0, p_big});

                always_ff @(posedge i_clk) begin
                    if (i_en) begin
                        r_num[i][k] <= p_num[k];
                        r_rem[i][k] <= w_ge ? RQ'(w_sh - {1'b0, p_big}) : RQ'(w_sh);
                        r_quo[i][k] <= {p_quo[k][NW-2:0], w_ge};
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[i] <= 1'b0;
                end else if (i_en) begin
                    r_v[i] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_big[i] <= p_big;
                    r_ctl[i] <= p_ctl;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[NW-1];
    assign o_big   = r_big[NW-1];
    assign o_ctl   = r_ctl[NW-1];
    assign o_quo   = r_quo[NW-1];

endmodule

// File: rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// 3x3 rotation matrix to unit quaternion, largest-diagonal method, pipelined.
//
//   Channel  Direction  Handshake          Word
//   matrix   in         i_valid / o_stall  i_m_r0c0 .. i_m_r2c2
//   quat     out        o_valid / i_stall  o_quat_x/y/z/w, o_saturated
//
// One word enters per cycle while o_stall is low. Words pass the front-end
// registers, R root stages and N divide stages, then a staging and an output
// register; the root and the divider retire one bit per stage. Reset clears
// all valid bits. When the output word is held by i_stall the pipe still moves
// while its last stage is empty; otherwise it freezes whole and o_stall rises.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
    parameter int DATA_WIDTH = rmq_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_m_r0c0,
    input  logic signed [DATA_WIDTH-1:0] i_m_r0c1,
    input  logic signed [DATA_WIDTH-1:0] i_m_r0c2,
    input  logic signed [DATA_WIDTH-1:0] i_m_r1c0,
    input  logic signed [DATA_WIDTH-1:0] i_m_r1c1,
    input  logic signed [DATA_WIDTH-1:0] i_m_r1c2,
    input  logic signed [DATA_WIDTH-1:0] i_m_r2c0,
    input  logic signed [DATA_WIDTH-1:0] i_m_r2c1,
    input  logic signed [DATA_WIDTH-1:0] i_m_r2c2,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_quat_x,
    output logic signed [DATA_WIDTH-1:0] o_quat_y,
    output logic signed [DATA_WIDTH-1:0] o_quat_z,
    output logic signed [DATA_WIDTH-1:0] o_quat_w,
    output logic                         o_saturated
);

    localparam int RW  = rmq_pkg::rad_w(DATA_WIDTH, FRAC_BITS);
    localparam int RQ  = rmq_pkg::root_w(DATA_WIDTH, FRAC_BITS);
    localparam int NW  = rmq_pkg::num_w(DATA_WIDTH, FRAC_BITS);
    localparam int DMW = DATA_WIDTH + 1;
    localparam int VW  = ((NW + 1) > (RQ + 1)) ? (NW + 1) : (RQ + 1);

    localparam logic signed [VW-1:0] SMAX = {{(VW-DATA_WIDTH+1){1'b0}},
                                             {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [VW-1:0] SMIN = ~SMAX;

    logic                  w_ce;
    logic                  w_ld;
    logic signed [DATA_WIDTH-1:0] w_m [9];

    logic                  f_v;
    logic [RW-1:0]         f_rad;
    rmq_pkg::t_ctl         f_ctl;
    logic [DMW-1:0]        f_mag [3];

    logic                  s_v;
    logic [RQ-1:0]         s_root;
    rmq_pkg::t_ctl         s_ctl;
    logic [DMW-1:0]        s_mag [3];

    logic                  d_v;
    logic [RQ-1:0]         d_big;
    rmq_pkg::t_ctl         d_ctl;
    logic [NW-1:0]         d_quo [3];

    logic signed [VW-1:0]  w_sq [3];
    logic signed [VW-1:0]  w_big;
    logic signed [VW-1:0]  w_q [4];
    logic [DATA_WIDTH-1:0] n_q [4];
    logic                  n_sat;

    logic                  r_sv;
    logic [DATA_WIDTH-1:0] r_sq [4];
    logic                  r_ssat;
    logic                  r_ov;
    logic [DATA_WIDTH-1:0] r_oq [4];
    logic                  r_osat;

    assign w_ld    = !r_ov || !i_stall;
    assign w_ce    = w_ld || !r_sv;
    assign o_stall = !w_ce;

    assign w_m[0] = i_m_r0c0;
    assign w_m[1] = i_m_r0c1;
    assign w_m[2] = i_m_r0c2;
    assign w_m[3] = i_m_r1c0;
    assign w_m[4] = i_m_r1c1;
    assign w_m[5] = i_m_r1c2;
    assign w_m[6] = i_m_r2c0;
    assign w_m[7] = i_m_r2c1;
    assign w_m[8] = i_m_r2c2;

    rmq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_ce),
        .i_valid (i_valid),
        .i_m     (w_m),
        .o_valid (f_v),
        .o_rad   (f_rad),
        .o_ctl   (f_ctl),
        .o_mag   (f_mag)
    );

    rmq_sqrt #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_ce),
        .i_valid (f_v),
        .i_rad   (f_rad),
        .i_ctl   (f_ctl),
        .i_mag   (f_mag),
        .o_valid (s_v),
        .o_root  (s_root),
        .o_ctl   (s_ctl),
        .o_mag   (s_mag)
    );

    rmq_div #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_ce),
        .i_valid (s_v),
        .i_big   (s_root),
        .i_ctl   (s_ctl),
        .i_mag   (s_mag),
        .o_valid (d_v),
        .o_big   (d_big),
        .o_ctl   (d_ctl),
        .o_quo   (d_quo)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sq[k] = d_ctl.neg[k] ? -VW'(d_quo[k]) : VW'(d_quo[k]);
        end
        w_big = VW'(d_big);
        // w_q order: x, y, z, w
        unique case (d_ctl.sel)
            rmq_pkg::SEL_W: begin
                w_q[0] = w_sq[0];
                w_q[1] = w_sq[1];
                w_q[2] = w_sq[2];
                w_q[3] = w_big;
            end
            rmq_pkg::SEL_X: begin
                w_q[0] = w_big;
                w_q[1] = w_sq[2];
                w_q[2] = w_sq[1];
                w_q[3] = w_sq[0];
            end
            rmq_pkg::SEL_Y: begin
                w_q[0] = w_sq[2];
                w_q[1] = w_big;
                w_q[2] = w_sq[0];
                w_q[3] = w_sq[1];
            end
            default: begin
                w_q[0] = w_sq[1];
                w_q[1] = w_sq[0];
                w_q[2] = w_big;
                w_q[3] = w_sq[2];
            end
        endcase
        n_sat = 1'b0;
        for (int k = 0; k < 4; k++) begin
            if (w_q[k] > SMAX) begin
                n_q[k] = DATA_WIDTH'(SMAX);
                n_sat  = 1'b1;
            end else if (w_q[k] < SMIN) begin
                n_q[k] = DATA_WIDTH'(SMIN);
                n_sat  = 1'b1;
            end else begin
                n_q[k] = DATA_WIDTH'(w_q[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (w_ce) begin
                r_sv <= d_v;
            end
            if (w_ld) begin
                r_ov <= r_sv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sq   <= n_q;
            r_ssat <= n_sat;
        end
        if (w_ld) begin
            r_oq   <= r_sq;
            r_osat <= r_ssat;
        end
    end

    assign o_valid     = r_ov;
    assign o_quat_x    = r_oq[0];
    assign o_quat_y    = r_oq[1];
    assign o_quat_z    = r_oq[2];
    assign o_quat_w    = r_oq[3];
    assign o_saturated = r_osat;

endmodule

// File: test/rotation_matrix_to_quaternion_tb.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Drives matrices into the quaternion pipe and checks every output word
// against a predictor built on the largest-diagonal method. Directed corner
// matrices come first, then random and rotation-like matrices with random
// idling on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;

    localparam int DW      = rmq_pkg::DATA_WIDTH_DEF;
    localparam int FB      = rmq_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 60;
    localparam int LIMIT   = 400000;

    typedef logic signed [DW-1:0] t_word;

    typedef struct {
        t_word x, y, z, w;
        logic  sat;
    } t_quat;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_stall;
    t_word mat [9] = '{default: '0};
    logic  o_valid;
    logic  i_stall = 1'b0;
    t_word o_quat_x, o_quat_y, o_quat_z, o_quat_w;
    logic  o_saturated;

    t_quat quat_fifo[$];
    int    errors = 0;
    int    words_in = 0;
    int    words_out = 0;
    int    cycles = 0;
    bit    idle_en = 1'b1;
    bit    hold_req = 1'b0;
    bit    hold_done = 1'b0;

    rotation_matrix_to_quaternion u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_m_r0c0   (mat[0]),
        .i_m_r0c1   (mat[1]),
        .i_m_r0c2   (mat[2]),
        .i_m_r1c0   (mat[3]),
        .i_m_r1c1   (mat[4]),
        .i_m_r1c2   (mat[5]),
        .i_m_r2c0   (mat[6]),
        .i_m_r2c1   (mat[7]),
        .i_m_r2c2   (mat[8]),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_quat_x   (o_quat_x),
        .o_quat_y   (o_quat_y),
        .o_quat_z   (o_quat_z),
        .o_quat_w   (o_quat_w),
        .o_saturated(o_saturated)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic longint quot_tz(longint d, longint b);
        longint mag;
        longint q;
        mag = (d < 0) ? -d : d;
        if (b == 0) return 0;
        q = (mag <<< (FB - 2)) / b;
        return (d < 0) ? -q : q;
    endfunction

    function automatic t_word clamp_word(longint v, ref logic sat);
        longint hi;
        hi = (longint'(1) <<< (DW - 1)) - 1;
        if (v > hi) begin
            sat = 1'b1;
            return t_word'(hi);
        end
        if (v < -hi - 1) begin
            sat = 1'b1;
            return t_word'(-hi - 1);
        end
        return t_word'(v);
    endfunction

    function automatic t_quat quat_of_matrix(t_word m [9]);
        longint t [4];
        longint q [4];
        longint rad, big, dx, dy, dz;
        rmq_pkg::t_sel pick;
        t_quat r;
        logic sat;
        t[0] = longint'(m[0]) + m[4] + m[8];
        t[1] = longint'(m[0]) - m[4] - m[8];
        t[2] = longint'(m[4]) - m[0] - m[8];
        t[3] = longint'(m[8]) - m[0] - m[4];
        pick = rmq_pkg::SEL_W;
        for (int k = 1; k < 4; k++)
            if (t[k] > t[int'(pick)]) pick = rmq_pkg::t_sel'(k);
        rad = (t[int'(pick)] + (longint'(1) <<< FB)) <<< (FB - 2);
        big = 0;
        for (int b = 31; b >= 0; b--)
            if ((big + (longint'(1) <<< b)) * (big + (longint'(1) <<< b)) <= rad)
                big += longint'(1) <<< b;
        dx = longint'(m[7]) - m[5];
        dy = longint'(m[2]) - m[6];
        dz = longint'(m[3]) - m[1];
        case (pick)
            rmq_pkg::SEL_W: begin
                q = '{big, quot_tz(dx, big), quot_tz(dy, big), quot_tz(dz, big)};
            end
            rmq_pkg::SEL_X: begin
                q = '{quot_tz(dx, big), big, quot_tz(dz, big), quot_tz(dy, big)};
            end
            rmq_pkg::SEL_Y: begin
                q = '{quot_tz(dy, big), quot_tz(dz, big), big, quot_tz(dx, big)};
            end
            default: begin
                q = '{quot_tz(dz, big), quot_tz(dy, big), quot_tz(dx, big), big};
            end
        endcase
        sat = 1'b0;
        r.x = clamp_word(q[1], sat);
        r.y = clamp_word(q[2], sat);
        r.z = clamp_word(q[3], sat);
        r.w = clamp_word(q[0], sat);
        r.sat = sat;
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch word %0d %s: got %0d want %0d", words_out, what, got, want);
        errors++;
    endtask

    task automatic send_matrix(t_word m [9]);
        if (idle_en && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        for (int k = 0; k < 9; k++) mat[k] <= m[k];
        i_valid <= 1'b1;
        quat_fifo.push_back(quat_of_matrix(m));
        words_in++;
        do @(posedge i_clk); while (o_stall);
    endtask

    // output side: random stall bursts, plus one long hold when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (idle_en && $urandom_range(0, 7) == 0) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_quat e;
            if (quat_fifo.size() == 0) begin
                report("unexpected word", 0, 0);
            end else begin
                e = quat_fifo.pop_front();
                if (o_quat_x !== e.x) report("x", o_quat_x, e.x);
                if (o_quat_y !== e.y) report("y", o_quat_y, e.y);
                if (o_quat_z !== e.z) report("z", o_quat_z, e.z);
                if (o_quat_w !== e.w) report("w", o_quat_w, e.w);
                if (o_saturated !== e.sat) report("saturated", o_saturated, e.sat);
            end
            words_out++;
        end
    end

    function automatic t_word rnd_word();
        return t_word'($urandom_range(0, 65535));
    endfunction

    task automatic test_corners();
        t_word m [9];
        t_word vals [5] = '{16'sh7fff, -16'sh8000, 16'sh0000, 16'sh4000, -16'sh4000};
        // identity and the three half-turn rotations, one per largest diagonal
        m = '{16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0, 16'sh4000};
        send_matrix(m);
        m = '{16'sh4000, 0, 0, 0, -16'sh4000, 0, 0, 0, -16'sh4000};
        send_matrix(m);
        m = '{-16'sh4000, 0, 0, 0, 16'sh4000, 0, 0, 0, -16'sh4000};
        send_matrix(m);
        m = '{-16'sh4000, 0, 0, 0, -16'sh4000, 0, 0, 0, 16'sh4000};
        send_matrix(m);
        // all-zero: every diagonal ties
        m = '{default: 0};
        send_matrix(m);
        // large off-diagonal differences drive the vector parts to full scale both ways
        m = '{0, -16'sh8000, 16'sh7fff, 16'sh7fff, 0, -16'sh8000, -16'sh8000, 16'sh7fff, 0};
        send_matrix(m);
        m = '{0, 16'sh7fff, -16'sh8000, -16'sh8000, 0, 16'sh7fff, 16'sh7fff, -16'sh8000, 0};
        send_matrix(m);
        for (int v = 0; v < 5; v++) begin
            m = '{default: vals[v]};
            send_matrix(m);
            m = '{vals[v], vals[(v+1)%5], vals[(v+2)%5], vals[(v+3)%5], vals[(v+4)%5],
                  vals[v], vals[(v+2)%5], vals[(v+4)%5], vals[(v+1)%5]};
            send_matrix(m);
        end
        // three equal leading diagonal sums: lowest index must win
        m = '{16'sh4000, 16'sh1000, -16'sh1000, 16'sh0800, 16'sh4000, 16'sh0100,
              -16'sh0200, 16'sh0300, -16'sh4000};
        send_matrix(m);
    endtask

    task automatic test_random(int n);
        t_word m [9];
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 2) == 0) begin
                for (int j = 0; j < 9; j++) m[j] = rnd_word();
            end else begin
                // near-rotation: one dominant diagonal pattern, small off-diagonals
                for (int j = 0; j < 9; j++)
                    m[j] = t_word'($signed($urandom_range(0, 16384)) - 8192);
                for (int j = 0; j < 9; j += 4)
                    m[j] = t_word'($signed($urandom_range(0, 32767)) - 16384);
            end
            send_matrix(m);
        end
    endtask

    task automatic test_backpressure();
        t_word m [9];
        hold_req = 1'b1;
        for (int k = 0; k < 120; k++) begin
            for (int j = 0; j < 9; j++) m[j] = rnd_word();
            send_matrix(m);
        end
    endtask

    task automatic drain();
        int wait_cycles;
        wait_cycles = 0;
        i_valid <= 1'b0;
        while (quat_fifo.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        repeat (LATENCY) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_random(250);
        test_backpressure();
        test_random(150);
        idle_en = 1'b0;
        test_random(80);
        drain();
        $display("%0d matrices sent, %0d quaternions checked", words_in, words_out);
        $display("corners, random and near-rotation matrices, idling and a long hold");
        if (errors == 0 && quat_fifo.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: rotation_matrix_to_quaternion.f
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_sqrt.sv
rtl/rmq_div.sv
rtl/rotation_matrix_to_quaternion.sv
test/rotation_matrix_to_quaternion_tb.sv
